@@ rtl/spq_pkg.sv @@
// shared types, constants and command codes of the sorted priority queue
package spq_pkg;

    // store geometry
    localparam int DEPTH         = 16;
    localparam int IDX_W         = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int PAYLOAD_WIDTH = 32;

    // command codes
    localparam logic [2:0] CMD_INSERT      = 3'd0;
    localparam logic [2:0] CMD_REMOVE      = 3'd1;
    localparam logic [2:0] CMD_READ_FRONT  = 3'd2;
    localparam logic [2:0] CMD_READ_BACK   = 3'd3;
    localparam logic [2:0] CMD_READ_MATCH  = 3'd4;
    localparam logic [2:0] CMD_WRITE_FRONT = 3'd5;
    localparam logic [2:0] CMD_WRITE_BACK  = 3'd6;
    localparam logic [2:0] CMD_WRITE_MATCH = 3'd7;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ENTRY = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // input word
    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] key_priority;
        logic [31:0]        payload;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_payload;
        logic [4:0]  entry_count;
        logic        is_empty;
    } t_out_word;

    // controller commands to the datapath
    typedef struct packed {
        logic load_in;
        logic compare;
        logic exec;
    } t_dp_ctl;

endpackage

@@ rtl/sorted_priority_queue.sv @@
// top level of the sorted priority queue
//
// Bounded queue of up to 16 entries kept in ascending signed priority order.
// Input channel: i_in_valid / o_in_stall carry one command word (cmd,
// key_priority, payload). Output channel: o_out_valid / i_out_stall carry one
// result word (status, read_payload, entry_count, is_empty) per command.
// A word moves on a rising edge where valid is high and stall is low.
// After a command is accepted, the controller compares its key in parallel
// against all slots, then executes it and registers the result.
// Commands are taken one at a time: after capture the input stalls through the
// compare and execute steps of the controller; the next command is taken while
// the previous result still waits in the output register.
// If the receiver stalls, the result holds in the output register; a further
// command is accepted and compared but waits in its execute step until the
// output register is free.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; slot contents are not cleared.
module sorted_priority_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  spq_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output spq_pkg::t_out_word  o_out_word
);

    spq_pkg::t_dp_ctl ctl;

    // sequencing of each command
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_ctl       (ctl)
    );

    // slot store and result
    spq_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_in_word  (i_in_word),
        .o_out_word (o_out_word)
    );

endmodule

@@ rtl/spq_ctrl.sv @@
// controller state machine of the sorted priority queue
module spq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output spq_pkg::t_dp_ctl o_ctl
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    // output register can take a new word this cycle
    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        n_out_valid   = r_out_valid && i_out_stall;
        o_ctl.load_in = 1'b0;
        o_ctl.compare = 1'b0;
        o_ctl.exec    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = S_CMP;
                end
            end
            S_CMP: begin
                o_ctl.compare = 1'b1;
                n_state       = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) begin
                    o_ctl.exec  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/spq_datapath.sv @@
// slot store, parallel compare and result register of the sorted priority queue
module spq_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spq_pkg::t_dp_ctl  i_ctl,
    input  spq_pkg::t_in_word i_in_word,
    output spq_pkg::t_out_word o_out_word
);

    localparam int DEPTH = spq_pkg::DEPTH;
    localparam int IDX_W = spq_pkg::IDX_W;
    localparam int CNT_W = spq_pkg::CNT_W;
    localparam int PW    = spq_pkg::PAYLOAD_WIDTH;

    // slot store, front at index 0
    logic signed [31:0] r_slot_prio [DEPTH];
    logic [PW-1:0]      r_slot_pl   [DEPTH];
    logic [CNT_W-1:0]   r_count, n_count;

    // captured command word and compare vectors
    logic [2:0]         r_cmd;
    logic signed [31:0] r_key;
    logic [PW-1:0]      r_pl;
    logic [DEPTH-1:0]   r_lt;
    logic [DEPTH-1:0]   r_eq;

    spq_pkg::t_out_word r_out;

    logic [IDX_W-1:0] ins_pos;
    logic [IDX_W-1:0] match_idx;
    logic             match_found;
    logic [IDX_W-1:0] sel_idx;
    logic             sel_found;
    logic             is_full;
    logic             is_read;
    logic             is_write;
    logic             do_insert;
    logic             do_remove;
    logic             do_write;
    logic [1:0]       status;
    logic [31:0]      rd_data;

    // capture the accepted word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_cmd <= i_in_word.cmd;
            r_key <= i_in_word.key_priority;
            r_pl  <= PW'(i_in_word.payload);
        end
    end

    // compare the key against every held slot
    always_ff @(posedge i_clk) begin
        if (i_ctl.compare) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_lt[i] <= (CNT_W'(i) < r_count) && (r_slot_prio[i] < r_key);
                r_eq[i] <= (CNT_W'(i) < r_count) && (r_slot_prio[i] == r_key);
            end
        end
    end

    // insert position and first match
    always_comb begin
        ins_pos     = '0;
        match_idx   = '0;
        match_found = 1'b0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_lt[i]) begin
                ins_pos = IDX_W'(i);
            end
            if (r_eq[i]) begin
                match_idx   = IDX_W'(i);
                match_found = 1'b1;
            end
        end
    end

    // target slot and outcome of the command
    always_comb begin
        is_full   = (r_count == CNT_W'(DEPTH));
        is_read   = 1'b0;
        is_write  = 1'b0;
        sel_idx   = match_idx;
        sel_found = match_found;
        case (r_cmd)
            spq_pkg::CMD_READ_FRONT, spq_pkg::CMD_WRITE_FRONT: begin
                sel_idx   = '0;
                sel_found = (r_count != '0);
            end
            spq_pkg::CMD_READ_BACK, spq_pkg::CMD_WRITE_BACK: begin
                sel_idx   = IDX_W'(r_count - CNT_W'(1));
                sel_found = (r_count != '0);
            end
            default: begin
                sel_idx   = match_idx;
                sel_found = match_found;
            end
        endcase
        is_read   = (r_cmd == spq_pkg::CMD_READ_FRONT) || (r_cmd == spq_pkg::CMD_READ_BACK)
                 || (r_cmd == spq_pkg::CMD_READ_MATCH);
        is_write  = (r_cmd == spq_pkg::CMD_WRITE_FRONT) || (r_cmd == spq_pkg::CMD_WRITE_BACK)
                 || (r_cmd == spq_pkg::CMD_WRITE_MATCH);
        do_insert = (r_cmd == spq_pkg::CMD_INSERT) && !is_full;
        do_remove = (r_cmd == spq_pkg::CMD_REMOVE) && sel_found;
        do_write  = is_write && sel_found;

        if (r_cmd == spq_pkg::CMD_INSERT) begin
            status = is_full ? spq_pkg::ST_FULL : spq_pkg::ST_OK;
        end else begin
            status = sel_found ? spq_pkg::ST_OK : spq_pkg::ST_NO_ENTRY;
        end

        rd_data = '0;
        if (is_read && sel_found) begin
            rd_data = 32'(r_slot_pl[sel_idx]);
        end

        n_count = r_count;
        if (do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // slot shifts and payload writes
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (do_insert) begin
                    if (IDX_W'(i) == ins_pos) begin
                        r_slot_prio[i] <= r_key;
                        r_slot_pl[i]   <= r_pl;
                    end else if ((i > 0) && (IDX_W'(i) > ins_pos)) begin
                        r_slot_prio[i] <= r_slot_prio[(i > 0) ? i - 1 : 0];
                        r_slot_pl[i]   <= r_slot_pl[(i > 0) ? i - 1 : 0];
                    end
                end else if (do_remove) begin
                    if ((i < DEPTH - 1) && (IDX_W'(i) >= sel_idx)) begin
                        r_slot_prio[i] <= r_slot_prio[(i < DEPTH - 1) ? i + 1 : i];
                        r_slot_pl[i]   <= r_slot_pl[(i < DEPTH - 1) ? i + 1 : i];
                    end
                end else if (do_write && (IDX_W'(i) == sel_idx)) begin
                    r_slot_pl[i] <= r_pl;
                end
            end
        end
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.exec) begin
            r_count <= n_count;
        end
    end

    // result word register
    always_ff @(posedge i_clk) begin
        if (i_ctl.exec) begin
            r_out.status       <= status;
            r_out.read_payload <= rd_data;
            r_out.entry_count  <= 5'(n_count);
            r_out.is_empty     <= (n_count == '0);
        end
    end

    assign o_out_word = r_out;

endmodule
